// ===== rtl/tbf_pkg.sv =====
// ----------------------------------------------------------------------------
// tbf_pkg : shared types and helpers for the timing Bloom filter
// Item and result layouts, command codes, controller/datapath bundles,
// the live-window test and the saturating counter step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbf_pkg;

  localparam int CELLS_DEFAULT = 4096;
  localparam int IDX_W         = 12;
  localparam int TS_W          = 4;
  localparam int CNT_W         = 13;
  localparam int KIND_W        = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [KIND_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] CMD_TEST  = 2'd1;
  localparam logic [KIND_W-1:0] CMD_DECAY = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] command;
    logic [IDX_W-1:0]  index;
    logic [TS_W-1:0]   tick;
    logic [TS_W-1:0]   window_min;
    logic [TS_W-1:0]   window_max;
    logic              last;
  } tbf_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] reply_kind;
    logic [CNT_W-1:0]  count;
    logic              present;
  } tbf_result_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;  // write zero at walk address, advance
    logic load;      // capture item, read its cell
    logic rmw;       // finish an add or test item
    logic walk_rd;   // decay: read walk address, advance
    logic drain;     // decay: last cell in flight, emit result
  } tbf_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic              walk_last;
    logic [KIND_W-1:0] in_cmd;
  } tbf_stat_t;

  // window (wmin, wmax], wrapping when wmax < wmin; zero is never live
  function automatic logic is_live(input logic [TS_W-1:0] v,
                                   input logic [TS_W-1:0] wmin,
                                   input logic [TS_W-1:0] wmax);
    logic            wrap;
    logic            outside;
    logic [TS_W-1:0] lo;
    logic [TS_W-1:0] hi;
    wrap    = wmax < wmin;
    lo      = wrap ? wmax : wmin;
    hi      = wrap ? wmin : wmax;
    outside = (v > hi) || (v <= lo);
    return (v != '0) && (outside == wrap);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// ===== rtl/timing_bloom_filter.sv =====
// ----------------------------------------------------------------------------
// timing_bloom_filter : timing Bloom filter over 4-bit timestamp cells
// Add and test items read their cell, then update it; for a group's last item
//   the result strobe follows in the cycle after the update. Decay walks the
//   store one cell per cycle through its separate read and write ports.
// After reset, busy stays high while the store is cleared.
// done is high for one cycle per result; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timing_bloom_filter import tbf_pkg::*; #(
  parameter int CELLS = CELLS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  tbf_item_t   item,
  output logic        busy,
  output tbf_result_t result,
  output logic        done
);

  // Command and status bundles between sequencer and datapath.
  tbf_ctl_t  ctl;
  tbf_stat_t stat;

  // Sequencer: clearing pass after reset, add/test read-then-update transfer,
  // decay walk with a drain cycle for the last cell in flight.
  tbf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .ctl  (ctl),
    .busy (busy)
  );

  // Datapath: cell store, group accumulators, decay counter and the
  // registered result, whose done strobe is high for exactly one cycle.
  tbf_datapath #(
    .CELLS(CELLS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .item  (item),
    .stat  (stat),
    .result(result),
    .done  (done)
  );

  // A result only ever follows an update or drain cycle.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.rmw || ctl.drain))
    else $error("result strobe without a finishing cycle");

  // The clearing pass holds the block busy straight after reset.
  a_clear_busy: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("not busy after reset");

  // A result never carries both a count and a present flag.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.present && result.count != '0))
    else $error("count and present both set");

  // An accepted decay transfer starts the walk.
  a_decay_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.command == CMD_DECAY) |=> busy)
    else $error("decay accepted but block idle");

endmodule

// ===== rtl/tbf_ram.sv =====
// ----------------------------------------------------------------------------
// tbf_ram : generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbf_ctrl : sequencer for the timing Bloom filter
// Runs the clearing pass, the add/test read-then-update access and the decay walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbf_ctrl import tbf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  tbf_stat_t stat,
  output tbf_ctl_t  ctl,
  output logic      busy
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_DECAY = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_CLEAR: begin
        ctl.clear_wr = 1'b1;
        if (stat.walk_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        ctl.load = start;
        if (start) begin
          case (stat.in_cmd)
            CMD_ADD, CMD_TEST: state_next = S_RMW;
            CMD_DECAY:         state_next = S_DECAY;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_RMW: begin
        ctl.rmw    = 1'b1;
        state_next = S_IDLE;
      end
      S_DECAY: begin
        ctl.walk_rd = 1'b1;
        if (stat.walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        ctl.drain  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/tbf_datapath.sv =====
// ----------------------------------------------------------------------------
// tbf_datapath : cell store, group accumulators and result register
// Read-modify-write of single cells, a one-deep decay pipeline and the
// result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbf_datapath import tbf_pkg::*; #(
  parameter int CELLS = CELLS_DEFAULT,
  localparam int AW   = $clog2(CELLS)
) (
  input  logic        clk,
  input  logic        rst,
  input  tbf_ctl_t    ctl,
  input  tbf_item_t   item,
  output tbf_stat_t   stat,
  output tbf_result_t result,
  output logic        done
);

  tbf_item_t        lat;
  logic [AW-1:0]    walk_addr;
  logic [AW-1:0]    proc_addr;
  logic             proc_valid;
  logic [CNT_W-1:0] group_count;
  logic             group_present;
  logic [CNT_W-1:0] live;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [TS_W-1:0]  wdata;
  logic [AW-1:0]    raddr;
  logic [TS_W-1:0]  rdata;

  logic             lat_inside;
  logic             lat_is_add;
  logic             cell_live;
  logic [CNT_W-1:0] gc_next;
  logic             gp_next;
  logic [CNT_W-1:0] live_next;

  assign lat_inside = 32'(lat.index) < CELLS;
  assign lat_is_add = (lat.command == CMD_ADD);
  assign cell_live  = is_live(rdata, lat.window_min, lat.window_max);

  assign gc_next   = (lat_inside && rdata == '0) ? sat_inc(group_count) : group_count;
  assign gp_next   = group_present & lat_inside & cell_live;
  assign live_next = (proc_valid && cell_live) ? sat_inc(live) : live;

  assign raddr = ctl.walk_rd ? walk_addr : AW'(item.index);

  always_comb begin
    we    = 1'b0;
    waddr = proc_addr;
    wdata = '0;
    if (ctl.clear_wr) begin
      we    = 1'b1;
      waddr = walk_addr;
    end else if (ctl.rmw) begin
      we    = lat_is_add && lat_inside;
      waddr = AW'(lat.index);
      wdata = lat.tick;
    end else if (proc_valid) begin
      // decay: drop stamped cells that have left the window
      we = (rdata != '0) && !cell_live;
    end
  end

  tbf_ram #(
    .WIDTH(TS_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) lat <= item;
    proc_addr <= walk_addr;
    if (ctl.rmw) begin
      result.reply_kind <= lat.command;
      result.count      <= lat_is_add ? gc_next : '0;
      result.present    <= lat_is_add ? 1'b0 : gp_next;
    end else if (ctl.drain) begin
      result.reply_kind <= CMD_DECAY;
      result.count      <= live_next;
      result.present    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_addr     <= '0;
      proc_valid    <= 1'b0;
      group_count   <= '0;
      group_present <= 1'b1;
      live          <= '0;
      done          <= 1'b0;
    end else begin
      proc_valid <= ctl.walk_rd;
      done       <= (ctl.rmw && lat.last) || ctl.drain;
      if (ctl.load) begin
        walk_addr <= '0;
        live      <= '0;
      end else if (ctl.clear_wr || ctl.walk_rd) begin
        walk_addr <= walk_addr + 1'b1;
      end
      if (proc_valid) live <= live_next;
      if (ctl.rmw) begin
        if (lat_is_add) begin
          group_count <= lat.last ? '0 : gc_next;
        end else begin
          group_present <= lat.last ? 1'b1 : gp_next;
        end
      end
    end
  end

  assign stat.walk_last = (walk_addr == AW'(CELLS - 1));
  assign stat.in_cmd    = item.command;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the timing Bloom filter
// Drives add, test, decay and unused-command items through the start/busy
// handshake, predicts every result from a behavioural copy of the cell
// store and checks each done strobe against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import tbf_pkg::*;;

  localparam int FILTER_CELLS = CELLS_DEFAULT;

  // Command 3 is not decoded by the block; named here for the noise items.
  localparam logic [KIND_W-1:0] CMD_UNUSED = 2'd3;

  // Items sent by the random phase (command 3 items are not counted).
  localparam int RANDOM_ITEMS = 1030;

  // Longest correct quiet stretch is the clearing pass after reset or one
  // decay walk, plus a sender gap; allow several times that.
  localparam int QUIET_LIMIT = 4 * (FILTER_CELLS + 64);

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  tbf_item_t   item_bus;
  logic        busy;
  tbf_result_t res_bus;
  logic        done;

  timing_bloom_filter #(
    .CELLS(FILTER_CELLS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item_bus),
    .busy  (busy),
    .result(res_bus),
    .done  (done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the cell store and the two group
  // accumulators, updated in transfer order.
  // --------------------------------------------------------------------------
  logic [TS_W-1:0]  cell_ts [FILTER_CELLS];
  logic [CNT_W-1:0] fill_tally;   // cells newly filled in the open add group
  logic             all_live;     // AND over the open test group

  tbf_result_t      pending_results [$];
  logic [IDX_W-1:0] recent_idx [$];  // cells written lately, reused by tests

  int unsigned mismatch_count;
  int unsigned filter_items;     // transfers of real commands
  bit          no_gaps;          // back-to-back stretch on the sender side
  logic [TS_W-1:0] now_tick;     // notional current time for random traffic

  // Live window is (wmin, wmax]; it wraps when wmax < wmin and is empty when
  // the two ends meet. An empty cell is never live.
  function automatic bit ts_in_window(input logic [TS_W-1:0] v,
                                      input logic [TS_W-1:0] wmin,
                                      input logic [TS_W-1:0] wmax);
    if (v == '0 || wmin == wmax) return 1'b0;
    if (wmin < wmax) return (v > wmin) && (v <= wmax);
    return (v > wmin) || (v <= wmax);
  endfunction

  // Apply one accepted item to the predicted store and queue any result.
  function automatic void predict_filter(input tbf_item_t it);
    tbf_result_t      r;
    logic [CNT_W-1:0] live;
    logic [TS_W-1:0]  v;
    bit               in_range;
    r            = '0;
    r.reply_kind = it.command;
    in_range     = (32'(it.index) < FILTER_CELLS);
    case (it.command)
      CMD_ADD: begin
        // a cell counts as newly filled if empty before, even for a zero tick
        if (in_range) begin
          if (cell_ts[it.index] == '0 && fill_tally != COUNT_MAX)
            fill_tally = fill_tally + 1'b1;
          cell_ts[it.index] = it.tick;
        end
        if (it.last) begin
          r.count = fill_tally;
          pending_results.push_back(r);
          fill_tally = '0;
        end
      end
      CMD_TEST: begin
        // keep reading after a miss; the flag stays low until emitted
        v = in_range ? cell_ts[it.index] : '0;
        if (!ts_in_window(v, it.window_min, it.window_max))
          all_live = 1'b0;
        if (it.last) begin
          r.present = all_live;
          pending_results.push_back(r);
          all_live = 1'b1;
        end
      end
      CMD_DECAY: begin
        live = '0;
        for (int i = 0; i < FILTER_CELLS; i++) begin
          if (cell_ts[i] != '0) begin
            if (ts_in_window(cell_ts[i], it.window_min, it.window_max)) begin
              if (live != COUNT_MAX) live = live + 1'b1;
            end else begin
              cell_ts[i] = '0;
            end
          end
        end
        r.count = live;
        pending_results.push_back(r);
      end
      default: ;  // unused command: no effect, no result
    endcase
  endfunction

  function automatic tbf_item_t mk_item(input logic [KIND_W-1:0] cmd,
                                        input logic [IDX_W-1:0]  idx,
                                        input logic [TS_W-1:0]   tick,
                                        input logic [TS_W-1:0]   wmin,
                                        input logic [TS_W-1:0]   wmax,
                                        input logic              last);
    tbf_item_t it;
    it.command    = cmd;
    it.index      = idx;
    it.tick       = tick;
    it.window_min = wmin;
    it.window_max = wmax;
    it.last       = last;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Drives at the falling edge, sees the transfer at the rising edge
  // where start is high and busy low, then draws its gap before the next one.
  // start is left high after a gap-free transfer; anything that pauses the
  // sender must lower it first (see hold_until_drained).
  // --------------------------------------------------------------------------
  task automatic send_item(input tbf_item_t it);
    int gap;
    @(negedge clk);
    start    <= 1'b1;
    item_bus <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predict_filter(it);
    if (it.command != CMD_UNUSED) filter_items++;
    if (it.command == CMD_ADD) begin
      recent_idx.push_back(it.index);
      if (recent_idx.size() > 64) void'(recent_idx.pop_front());
    end
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Sender stops until every predicted result has been seen.
  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: each strobe is compared with the oldest prediction.
  // --------------------------------------------------------------------------
  function automatic void note_mismatch(input string what,
                                        input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %0d at %0t: %s expected %0h actual %0h",
               mismatch_count, $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    tbf_result_t want;
    if (rst === 1'b0 && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with none pending, count", '0, res_bus.count);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.reply_kind !== want.reply_kind)
          note_mismatch("reply_kind", want.reply_kind, res_bus.reply_kind);
        if (res_bus.count !== want.count)
          note_mismatch("count", want.count, res_bus.count);
        if (res_bus.present !== want.present)
          note_mismatch("present", want.present, res_bus.present);
      end
    end
  end

  // Watchdog: ends the run if no transfer in either direction for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // First and last cell, tick and window extremes, re-add of a filled cell.
  task automatic test_boundary_cells();
    send_item(mk_item(CMD_ADD,  '0,  4'd15, 4'd0,  4'd0,  1'b0));
    send_item(mk_item(CMD_ADD,  '1,  4'd1,  4'd0,  4'd0,  1'b1));
    send_item(mk_item(CMD_ADD,  '0,  4'd8,  4'd15, 4'd15, 1'b1));
    send_item(mk_item(CMD_TEST, '0,  4'd0,  4'd0,  4'd15, 1'b1));
    send_item(mk_item(CMD_TEST, '1,  4'd15, 4'd15, 4'd0,  1'b1));  // wrapped
    send_item(mk_item(CMD_TEST, '1,  4'd0,  4'd7,  4'd7,  1'b1));  // empty
  endtask

  // Zero tick leaves the cell empty but still counts as newly filled.
  task automatic test_zero_tick();
    send_item(mk_item(CMD_ADD,  12'd9, 4'd0, 4'd0, 4'd0,  1'b0));
    send_item(mk_item(CMD_ADD,  12'd9, 4'd0, 4'd0, 4'd0,  1'b1));
    send_item(mk_item(CMD_TEST, 12'd9, 4'd0, 4'd0, 4'd15, 1'b1));
  endtask

  // Command 3 must neither answer nor disturb the store.
  task automatic test_unused_command();
    send_item(mk_item(CMD_UNUSED, '1, 4'd15, 4'd15, 4'd15, 1'b1));
    send_item(mk_item(CMD_UNUSED, '0, 4'd0,  4'd0,  4'd0,  1'b0));
    send_item(mk_item(CMD_TEST,   '0, 4'd0,  4'd7,  4'd8,  1'b1));
  endtask

  // A miss early in a group holds the flag low; the next group starts afresh.
  task automatic test_miss_then_live();
    send_item(mk_item(CMD_TEST, '1, 4'd0, 4'd1, 4'd3,  1'b0));
    send_item(mk_item(CMD_TEST, '0, 4'd0, 4'd0, 4'd15, 1'b1));
    send_item(mk_item(CMD_TEST, '0, 4'd0, 4'd0, 4'd15, 1'b1));
  endtask

  // Add and test items interleaved; each accumulator only sees its own kind.
  task automatic test_mixed_groups();
    send_item(mk_item(CMD_ADD,  12'd20, 4'd3, 4'd0, 4'd0,  1'b0));
    send_item(mk_item(CMD_TEST, 12'd0,  4'd0, 4'd0, 4'd15, 1'b0));
    send_item(mk_item(CMD_ADD,  12'd21, 4'd3, 4'd0, 4'd0,  1'b0));
    send_item(mk_item(CMD_TEST, 12'd21, 4'd0, 4'd2, 4'd3,  1'b1));
    send_item(mk_item(CMD_ADD,  12'd22, 4'd3, 4'd0, 4'd0,  1'b1));
  endtask

  // Decay clears cells outside the window and reports the survivors.
  task automatic test_decay_walk();
    send_item(mk_item(CMD_DECAY, '0, 4'd0, 4'd2, 4'd8,  1'b0));
    send_item(mk_item(CMD_TEST,  '1, 4'd0, 4'd0, 4'd15, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------

  // Most often a small hot region so cells collide, plus recent, edge and any.
  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return IDX_W'($urandom_range(0, 63));
    if (r < 6 && recent_idx.size() > 0)
      return recent_idx[$urandom_range(0, recent_idx.size() - 1)];
    if (r == 6) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return IDX_W'($urandom());
  endfunction

  // Window ending at the current tick, so fresh cells are usually live.
  function automatic logic [2*TS_W-1:0] pick_window();
    logic [TS_W-1:0] wmin;
    logic [TS_W-1:0] wmax;
    if ($urandom_range(0, 4) == 0) begin
      wmin = TS_W'($urandom());
      wmax = TS_W'($urandom());
    end else begin
      wmax = now_tick;
      wmin = now_tick - TS_W'($urandom_range(1, 15));
    end
    return {wmin, wmax};
  endfunction

  task automatic send_add_group(input int len, input bit closed);
    logic [TS_W-1:0] tick;
    int r;
    for (int i = 0; i < len; i++) begin
      r    = $urandom_range(0, 19);
      tick = (r == 0) ? '0 : (r < 3) ? TS_W'($urandom()) : now_tick;
      send_item(mk_item(CMD_ADD, pick_index(), tick, TS_W'($urandom()),
                        TS_W'($urandom()), closed && (i == len - 1)));
    end
  endtask

  task automatic send_test_group(input int len, input bit closed);
    logic [2*TS_W-1:0] win;
    logic [IDX_W-1:0]  idx;
    for (int i = 0; i < len; i++) begin
      win = pick_window();
      if (recent_idx.size() > 0 && $urandom_range(0, 9) < 7)
        idx = recent_idx[$urandom_range(0, recent_idx.size() - 1)];
      else
        idx = pick_index();
      send_item(mk_item(CMD_TEST, idx, TS_W'($urandom()), win[2*TS_W-1:TS_W],
                        win[TS_W-1:0], closed && (i == len - 1)));
    end
  endtask

  task automatic run_random_traffic();
    int unsigned goal;
    int kind;
    logic [2*TS_W-1:0] win;
    goal = filter_items + RANDOM_ITEMS;
    while (filter_items < goal) begin
      if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
      if ($urandom_range(0, 3) == 0) now_tick = (now_tick == 4'd15) ? 4'd1 : now_tick + 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_add_group($urandom_range(1, 6), 1'b1);
      end else if (kind < 75) begin
        send_test_group($urandom_range(1, 6), 1'b1);
      end else if (kind < 81) begin
        // open groups of both kinds, closed in either order
        send_add_group($urandom_range(1, 3), 1'b0);
        send_test_group($urandom_range(1, 3), 1'b0);
        if ($urandom_range(0, 1) != 0) send_add_group(1, 1'b1);
        send_test_group(1, 1'b1);
        send_add_group(1, 1'b1);
      end else if (kind < 84) begin
        win = pick_window();
        send_item(mk_item(CMD_DECAY, IDX_W'($urandom()), TS_W'($urandom()),
                          win[2*TS_W-1:TS_W], win[TS_W-1:0], 1'($urandom())));
      end else if (kind < 92) begin
        // noise: any command, any field
        send_item(mk_item(KIND_W'($urandom()), IDX_W'($urandom()), TS_W'($urandom()),
                          TS_W'($urandom()), TS_W'($urandom()), 1'($urandom())));
      end else if (kind < 97) begin
        // broken group: no last, so it runs on into whatever follows
        if ($urandom_range(0, 1) != 0) send_add_group($urandom_range(1, 4), 1'b0);
        else send_test_group($urandom_range(1, 4), 1'b0);
      end else begin
        hold_until_drained();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    item_bus       = '0;
    fill_tally     = '0;
    all_live       = 1'b1;
    mismatch_count = 0;
    filter_items   = 0;
    no_gaps        = 1'b0;
    now_tick       = 4'd1;
    for (int i = 0; i < FILTER_CELLS; i++) cell_ts[i] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // busy covers the clearing pass; the first transfer simply waits for it
    test_boundary_cells();
    test_zero_tick();
    test_unused_command();
    hold_until_drained();
    test_miss_then_live();
    test_mixed_groups();
    test_decay_walk();
    hold_until_drained();
    run_random_traffic();

    hold_until_drained();
    // a trailing no-result item may still be in flight: allow one decay walk
    repeat (FILTER_CELLS + 16) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding",
               mismatch_count, pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
